@@ design/ddt_pkg.sv @@
// Shared types and constants for the deadline timer table.
package ddt_pkg;

  // Default sizing of the table.
  localparam int unsigned TimersDef   = 32;
  localparam int unsigned TimeBitsDef = 64;

  // Fixed field widths of the stream payloads.
  localparam int unsigned OpW      = 3;
  localparam int unsigned IdW      = 5;
  localparam int unsigned CountW   = 6;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned KindW    = 3;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 80;

  // Request opcodes.
  typedef enum logic [OpW-1:0] {
    OP_SCHED_ABS   = 3'd0,
    OP_SCHED_REL   = 3'd1,
    OP_CANCEL      = 3'd2,
    OP_RESCHED_ABS = 3'd3,
    OP_RESCHED_REL = 3'd4,
    OP_PROCESS     = 3'd5,
    OP_QUERY       = 3'd6,
    OP_CLEAR       = 3'd7
  } op_e;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    RK_SCHEDULED = 3'd0,
    RK_STATUS    = 3'd1,
    RK_FIRED     = 3'd2,
    RK_DONE      = 3'd3,
    RK_NEXT      = 3'd4
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e             kind;
    logic              ok;
    logic [IdW-1:0]    id;
    logic [CountW-1:0] count;
    logic              has_next;
    logic [TimeW-1:0]  left;
    logic              last;
  } res_t;

endpackage

@@ design/ddt_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
module ddt_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/deadline_timer_table_top.sv @@
// Top level of the deadline timer table: request sequencer around the slot memory.
//
// Requests enter on the s_axis channel: tuser carries the opcode, tdata the
// current time, the timer id and the time value. Results leave on m_axis:
// tuser carries the result kind, tlast marks the final result of a request.
// Each slot holds its active flag and deadline in one memory word; all
// searches walk the memory one slot per cycle through its single read port.
// Schedule and query each walk the table once. Cancel and reschedule read only
// the addressed slot. Process walks the table once for every fired timer plus
// one more walk to find nothing due. Clear returns no result.
// One request is handled at a time; s_axis_tready_o is high when the
// sequencer is idle, even while a finished result waits in the output
// register. When the receiver stalls, the output register holds its result
// and the sequencer waits before producing the next one.
// After reset the block sweeps the memory to mark every slot inactive and
// accepts no request until the sweep is done.
module deadline_timer_table_top #(
  parameter int unsigned TIMERS    = ddt_pkg::TimersDef,
  parameter int unsigned TIME_BITS = ddt_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_time[63:0], timer_id[68:64], time_value[132:69], zero pad
  input  logic [ddt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // opcode[2:0]
  input  logic [ddt_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // ok[0], fired_id[5:1], fired_count[11:6], has_next[12], time_left[76:13], pad
  output logic [ddt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // result_kind[2:0]
  output logic [ddt_pkg::KindW-1:0]     m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import ddt_pkg::*;

  localparam int unsigned IW = $clog2(TIMERS);
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned MW = TB + 1;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_CHK  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [TB-1:0] now_q, now_d, dl_q, dl_d, bestdl_q, bestdl_d;
  logic [IdW-1:0] id_q, id_d;
  logic [IW:0] scan_q, scan_d;
  logic pend_q, pend_d, found_q, found_d, more_q, more_d;
  logic [IW-1:0] pidx_q, pidx_d, best_q, best_d;
  logic [CountW-1:0] fcnt_q, fcnt_d;
  res_t res_q, res_d, out_q, out_d;
  logic ovalid_q, ovalid_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;

  ddt_mem #(.Depth(TIMERS), .Width(MW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Request fields and the saturating relative deadline.
  logic [TB-1:0] in_now, in_tv, in_dl;
  logic [TB:0] in_sum;
  op_e in_op;
  logic [IdW-1:0] in_id;
  assign in_now = s_axis_tdata_i[TB-1:0];
  assign in_id  = s_axis_tdata_i[68:64];
  assign in_tv  = s_axis_tdata_i[69+TB-1:69];
  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_sum = {1'b0, in_now} + {1'b0, in_tv};
  always_comb begin
    if (in_op == OP_SCHED_REL || in_op == OP_RESCHED_REL) begin
      in_dl = in_sum[TB] ? {TB{1'b1}} : in_sum[TB-1:0];
    end else begin
      in_dl = in_tv;
    end
  end

  // Entry under evaluation during a walk.
  logic          act_r;
  logic [TB-1:0] dl_r;
  assign act_r = rdata[TB];
  assign dl_r  = rdata[TB-1:0];

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready_i;

  // Query answer from the registered best entry.
  logic [TB-1:0] left;
  always_comb begin
    if (!found_q || bestdl_q <= now_q) begin
      left = '0;
    end else begin
      left = bestdl_q - now_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    now_d    = now_q;
    dl_d     = dl_q;
    id_d     = id_q;
    scan_d   = scan_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    found_d  = found_q;
    best_d   = best_q;
    bestdl_d = bestdl_q;
    fcnt_d   = fcnt_q;
    more_d   = more_q;
    res_d    = res_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    we       = 1'b0;
    waddr    = best_q;
    wdata    = {1'b0, bestdl_q};
    raddr    = scan_q[IW-1:0];

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = scan_q[IW-1:0];
        wdata = '0;
        scan_d = scan_q + 1'b1;
        if (scan_q[IW-1:0] == IW'(TIMERS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = IW'(in_id);
        if (s_axis_tvalid_i) begin
          op_d    = in_op;
          now_d   = in_now;
          dl_d    = in_dl;
          id_d    = in_id;
          scan_d  = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          fcnt_d  = '0;
          more_d  = 1'b0;
          res_d   = '0;
          case (in_op)
            OP_CLEAR: state_d = S_CLR;
            OP_CANCEL, OP_RESCHED_ABS, OP_RESCHED_REL: begin
              if (32'(in_id) < 32'(TIMERS)) begin
                state_d = S_CHK;
              end else begin
                res_d.kind = RK_STATUS;
                res_d.last = 1'b1;
                state_d    = S_OUT;
              end
            end
            default: state_d = S_SCAN;
          endcase
        end
      end
      S_CHK: begin
        waddr = IW'(id_q);
        wdata = (op_q == OP_CANCEL) ? {1'b0, dl_r} : {1'b1, dl_q};
        we    = act_r;
        res_d.kind = RK_STATUS;
        res_d.ok   = act_r;
        res_d.last = 1'b1;
        state_d    = S_OUT;
      end
      S_SCAN: begin
        // Issue the next read.
        if (scan_q != (IW+1)'(TIMERS)) begin
          scan_d = scan_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = scan_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        // Evaluate the entry that arrived.
        if (pend_q) begin
          case (op_q)
            OP_PROCESS: begin
              if (act_r && dl_r <= now_q && (!found_q || dl_r < bestdl_q)) begin
                found_d = 1'b1; best_d = pidx_q; bestdl_d = dl_r;
              end
            end
            OP_QUERY: begin
              if (act_r && (!found_q || dl_r < bestdl_q)) begin
                found_d = 1'b1; best_d = pidx_q; bestdl_d = dl_r;
              end
            end
            default: begin
              if (!act_r && !found_q) begin
                found_d = 1'b1; best_d = pidx_q;
              end
            end
          endcase
          if (pidx_q == IW'(TIMERS - 1)) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_d = S_OUT;
        case (op_q)
          OP_PROCESS: begin
            if (found_q) begin
              we    = 1'b1;
              wdata = {1'b0, bestdl_q};
              res_d.kind = RK_FIRED;
              res_d.ok   = 1'b1;
              res_d.id   = IdW'(best_q);
              res_d.last = 1'b0;
              fcnt_d     = fcnt_q + 1'b1;
              more_d     = 1'b1;
            end else begin
              res_d.kind  = RK_DONE;
              res_d.ok    = 1'b1;
              res_d.id    = '0;
              res_d.count = fcnt_q;
              res_d.last  = 1'b1;
              more_d      = 1'b0;
            end
          end
          OP_QUERY: begin
            res_d.kind     = RK_NEXT;
            res_d.ok       = 1'b1;
            res_d.has_next = found_q;
            res_d.left     = TimeW'(left);
            res_d.last     = 1'b1;
          end
          default: begin
            we    = found_q;
            wdata = {1'b1, dl_q};
            res_d.kind = RK_SCHEDULED;
            res_d.ok   = found_q;
            res_d.id   = found_q ? IdW'(best_q) : '0;
            res_d.last = 1'b1;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
          if (more_q) begin
            scan_d  = '0;
            pend_d  = 1'b0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      more_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      more_q   <= more_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    now_q    <= now_d;
    dl_q     <= dl_d;
    id_q     <= id_d;
    pidx_q   <= pidx_d;
    best_q   <= best_d;
    bestdl_q <= bestdl_d;
    fcnt_q   <= fcnt_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Ports.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {3'b000, out_q.left, out_q.has_next, out_q.count,
                            out_q.id, out_q.ok};

endmodule

@@ bench/deadline_timer_table_top_test.sv @@
// Testbench for the deadline timer table: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module deadline_timer_table_top_test;
  import ddt_pkg::*;

  localparam int unsigned NumTimers = 32;

  // One expected or observed result.
  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [4:0]  id;
    logic [5:0]  count;
    logic        has_next;
    logic [63:0] left;
    logic        last;
  } timer_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [OpW-1:0]      s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [KindW-1:0]    m_axis_tuser_o;
  logic                m_axis_tlast_o;

  deadline_timer_table_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o),
    .m_axis_tlast_o(m_axis_tlast_o)
  );

  // Predictor state: a copy of the slot table.
  logic [63:0] pred_deadline [NumTimers];
  logic        pred_active [NumTimers];
  timer_res_t  expected_results[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;
  logic [63:0] sim_now;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
  endfunction

  // Lowest slot with the earliest active deadline, optionally only due ones.
  function automatic int earliest_slot(bit due_only, logic [63:0] now);
    int best;
    best = -1;
    for (int i = 0; i < NumTimers; i++) begin
      if (pred_active[i] && !(due_only && pred_deadline[i] > now)) begin
        if (best < 0 || pred_deadline[i] < pred_deadline[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic timer_res_t mk_res(kind_e k, logic ok, int id, int cnt,
                                        logic hn, logic [63:0] left, logic last);
    timer_res_t r;
    r.kind = k; r.ok = ok; r.id = id[4:0]; r.count = cnt[5:0];
    r.has_next = hn; r.left = left; r.last = last;
    return r;
  endfunction

  // Update the slot table and queue the results of one request.
  task automatic predict_timer_request(op_e op, logic [63:0] now, logic [4:0] id,
                                       logic [63:0] tv);
    logic [63:0] dl;
    int          s;
    int          n;
    bit          done;
    logic        was_active;
    case (op)
      OP_SCHED_ABS, OP_SCHED_REL: begin
        dl = (op == OP_SCHED_ABS) ? tv : sat_add(now, tv);
        done = 0;
        for (int i = 0; i < NumTimers && !done; i++) begin
          if (!pred_active[i]) begin
            pred_active[i] = 1'b1;
            pred_deadline[i] = dl;
            expected_results.push_back(mk_res(RK_SCHEDULED, 1'b1, i, 0, 1'b0, 64'd0, 1'b1));
            done = 1;
          end
        end
        if (!done)
          expected_results.push_back(mk_res(RK_SCHEDULED, 1'b0, 0, 0, 1'b0, 64'd0, 1'b1));
      end
      OP_CANCEL, OP_RESCHED_ABS, OP_RESCHED_REL: begin
        // The status reflects the slot before the update.
        was_active = pred_active[id];
        if (was_active) begin
          if (op == OP_CANCEL) pred_active[id] = 1'b0;
          else pred_deadline[id] = (op == OP_RESCHED_ABS) ? tv : sat_add(now, tv);
        end
        expected_results.push_back(mk_res(RK_STATUS, was_active, 0, 0, 1'b0, 64'd0, 1'b1));
      end
      OP_PROCESS: begin
        n = 0;
        s = earliest_slot(1'b1, now);
        while (s >= 0) begin
          pred_active[s] = 1'b0;
          expected_results.push_back(mk_res(RK_FIRED, 1'b1, s, 0, 1'b0, 64'd0, 1'b0));
          n++;
          s = earliest_slot(1'b1, now);
        end
        expected_results.push_back(mk_res(RK_DONE, 1'b1, 0, n, 1'b0, 64'd0, 1'b1));
      end
      OP_QUERY: begin
        s = earliest_slot(1'b0, now);
        if (s < 0)
          expected_results.push_back(mk_res(RK_NEXT, 1'b1, 0, 0, 1'b0, 64'd0, 1'b1));
        else
          expected_results.push_back(mk_res(RK_NEXT, 1'b1, 0, 0, 1'b1,
            (pred_deadline[s] <= now) ? 64'd0 : pred_deadline[s] - now, 1'b1));
      end
      default: begin
        for (int i = 0; i < NumTimers; i++) pred_active[i] = 1'b0;
      end
    endcase
  endtask

  // Send one request and update the predictor once it is accepted.
  task automatic send_timer_request(op_e op, logic [63:0] now, logic [4:0] id,
                                    logic [63:0] tv);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {3'b0, tv, id, now};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_timer_request(op, now, id, tv);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Random request, biased toward schedules and processes on a moving clock.
  task automatic send_random_request();
    int          pick;
    op_e         op;
    logic [63:0] tv;
    pick = $urandom_range(99, 0);
    if (pick < 30) op = ($urandom_range(1, 0) != 0) ? OP_SCHED_REL : OP_SCHED_ABS;
    else if (pick < 42) op = OP_CANCEL;
    else if (pick < 56) op = ($urandom_range(1, 0) != 0) ? OP_RESCHED_REL : OP_RESCHED_ABS;
    else if (pick < 78) op = OP_PROCESS;
    else if (pick < 96) op = OP_QUERY;
    else op = OP_CLEAR;
    sim_now = sim_now + 64'($urandom_range(40, 0));
    case ($urandom_range(9, 0))
      0: tv = {$urandom, $urandom};
      1: tv = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3, 0));
      default: tv = (op == OP_SCHED_ABS || op == OP_RESCHED_ABS) ?
                    sim_now + 64'($urandom_range(100, 0)) - 64'd20 :
                    64'($urandom_range(100, 0));
    endcase
    send_timer_request(op, ($urandom_range(49, 0) == 0) ? {$urandom, $urandom} : sim_now,
                       5'($urandom_range(31, 0)), tv);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    timer_res_t got;
    timer_res_t exp_res;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = m_axis_tuser_o;  got.ok = m_axis_tdata_o[0];
      got.id = m_axis_tdata_o[5:1];  got.count = m_axis_tdata_o[11:6];
      got.has_next = m_axis_tdata_o[12];  got.left = m_axis_tdata_o[76:13];
      got.last = m_axis_tlast_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (got !== exp_res) begin
          $display("%0t: result mismatch, expected kind %0d ok %0d id %0d count %0d next %0d left %0d last %0d, actual kind %0d ok %0d id %0d count %0d next %0d left %0d last %0d",
                   $time, exp_res.kind, exp_res.ok, exp_res.id, exp_res.count,
                   exp_res.has_next, exp_res.left, exp_res.last, got.kind, got.ok,
                   got.id, got.count, got.has_next, got.left, got.last);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure, including a long counted hold-off.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_timer_request(OP_QUERY, 64'd0, 5'd0, 64'd0);
    send_timer_request(OP_PROCESS, 64'd0, 5'd0, 64'd0);
    send_timer_request(OP_CANCEL, 64'd0, 5'd31, 64'd0);
    send_timer_request(OP_RESCHED_ABS, 64'd0, 5'd3, 64'd5);
    send_timer_request(OP_SCHED_ABS, 64'd100, 5'd0, 64'd150);
    send_timer_request(OP_SCHED_REL, 64'hFFFF_FFFF_FFFF_FFF0, 5'd31,
                       64'hFFFF_FFFF_FFFF_FFFF);
    send_timer_request(OP_SCHED_REL, 64'd100, 5'd0, 64'd20);
    send_timer_request(OP_SCHED_ABS, 64'd100, 5'd0, 64'd120);
    send_timer_request(OP_QUERY, 64'd100, 5'd0, 64'd0);
    send_timer_request(OP_RESCHED_REL, 64'd100, 5'd0, 64'd0);
    send_timer_request(OP_RESCHED_ABS, 64'd100, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_timer_request(OP_QUERY, 64'd130, 5'd0, 64'd0);
    send_timer_request(OP_PROCESS, 64'd130, 5'd0, 64'd0);
    send_timer_request(OP_CANCEL, 64'd0, 5'd3, 64'd0);
    send_timer_request(OP_CANCEL, 64'd0, 5'd3, 64'd0);
    // Fill the table; the last of these schedules finds it full.
    for (int i = 0; i < NumTimers; i++)
      send_timer_request(OP_SCHED_ABS, 64'd0, 5'd0, 64'd200 + (i % 3));
    send_timer_request(OP_PROCESS, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 64'd0);
    for (int i = 0; i < 4; i++)
      send_timer_request(OP_SCHED_REL, 64'd10, 5'd0, 64'd5);
    send_timer_request(OP_CLEAR, 64'd0, 5'd0, 64'd0);
    send_timer_request(OP_QUERY, 64'd0, 5'd0, 64'd0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_random_request();
  endtask

  // The receiver holds off while requests keep coming, so the block stalls.
  task automatic test_long_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_off_cycles = 600;
    for (int i = 0; i < 6; i++) send_random_request();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    m_axis_tready_i = 1'b1;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    sim_now = 64'd1000;
    for (int i = 0; i < NumTimers; i++) begin
      pred_active[i] = 1'b0;
      pred_deadline[i] = 64'd0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(0, 0, 68);
    test_long_hold_off();
    test_random_phase(67, 0, 68);
    test_random_phase(0, 67, 68);
    test_random_phase(16, 16, 68);
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
